>>> rtl/lzot_pkg.sv
// ----------------------------------------------------------------------------
// lzot_pkg
// Shared types and constants of the layer stacking-order table.
// ----------------------------------------------------------------------------
package lzot_pkg;

  // Default size of the layer pool.
  localparam int LAYER_COUNT_DEF = 256;

  // Request codes carried on the action field.
  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_SET   = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_CAPTURE,
    DP_SCAN_RD,
    DP_SCAN_CHK,
    DP_LOOK_RD,
    DP_LOOK_CHK,
    DP_MOVE_RD,
    DP_MOVE_WR,
    DP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic idx_last;    // scan or clear index is at the last slot
    logic scan_free;   // slot under scan is free
    logic look_valid;  // addressed slot is in use and the action applies
    logic need_move;   // the restack has layers to shift
    logic move_last;   // current shift step is the final one
  } status_t;

endpackage

>>> rtl/lzot_ram.sv
// ----------------------------------------------------------------------------
// lzot_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lzot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/lzot_ctrl.sv
// ----------------------------------------------------------------------------
// lzot_ctrl
// Controller of the layer table: sequences the clearing pass, the free-slot
// scan, the slot lookup and the one-layer-per-step restack.
// ----------------------------------------------------------------------------
module lzot_ctrl
  import lzot_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  action_i,
  output logic        busy_o,
  output logic        done_o,
  output cmd_t        cmd_o,
  input  status_t     status_i
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_LOOK_RD,
    S_LOOK_CHK,
    S_MOVE_RD,
    S_MOVE_WR,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    cmd_o.op  = DP_NOP;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = DP_CLEAR;
        if (status_i.idx_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = DP_CAPTURE;
          state_d  = (action_i == ACT_ALLOC) ? S_SCAN_RD : S_LOOK_RD;
        end
      end
      S_SCAN_RD: begin
        cmd_o.op = DP_SCAN_RD;
        state_d  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd_o.op = DP_SCAN_CHK;
        if (status_i.scan_free || status_i.idx_last) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_LOOK_RD: begin
        cmd_o.op = DP_LOOK_RD;
        state_d  = S_LOOK_CHK;
      end
      S_LOOK_CHK: begin
        cmd_o.op = DP_LOOK_CHK;
        if (!status_i.look_valid) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end else if (status_i.need_move) begin
          state_d = S_MOVE_RD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_MOVE_RD: begin
        cmd_o.op = DP_MOVE_RD;
        state_d  = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd_o.op = DP_MOVE_WR;
        state_d  = status_i.move_last ? S_FINISH : S_MOVE_RD;
      end
      S_FINISH: begin
        cmd_o.op = DP_FINISH;
        state_d  = S_IDLE;
        done_d   = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  // A result is only shown once the block is back in idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // A transfer in always starts work in the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not start");

  // Every request passes through at least a read state and a check state, so strobes never touch.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

>>> rtl/lzot_datapath.sv
// ----------------------------------------------------------------------------
// lzot_datapath
// Datapath of the layer table: slot-used, height and order memories, the
// stacking top register, the height clamp and the shift counters.
// ----------------------------------------------------------------------------
module lzot_datapath
  import lzot_pkg::*;
#(
  parameter int LAYER_COUNT = LAYER_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [1:0]         action_i,
  input  logic [7:0]         slot_i,
  input  logic signed [9:0]  wanted_height_i,
  output logic [7:0]         slot_out_o,
  output logic               ok_o,
  output logic signed [8:0]  new_height_o,
  output logic signed [8:0]  top_now_o,
  output logic               redraw_o
);

  localparam int IW = $clog2(LAYER_COUNT);
  localparam int HW = $clog2(LAYER_COUNT + 1) + 1;
  localparam int CW = ((HW > 10) ? HW : 10) + 1;
  localparam int XW = (IW > 8) ? IW : 8;
  localparam int OW = (HW > 9) ? HW : 9;

  localparam logic signed [HW-1:0] H_ONE = HW'(1);
  localparam logic signed [HW-1:0] H_NEG = '1;
  localparam logic signed [HW-1:0] H_MAX = HW'(LAYER_COUNT - 1);
  localparam logic signed [CW-1:0] C_ONE = CW'(1);
  localparam logic signed [CW-1:0] C_NEG = '1;
  localparam logic [IW-1:0]        I_LAST = IW'(LAYER_COUNT - 1);

  function automatic logic [8:0] h9(logic signed [HW-1:0] v);
    logic signed [OW-1:0] w;
    w = OW'(v);
    return w[8:0];
  endfunction

  function automatic logic [7:0] s8(logic [IW-1:0] v);
    logic [XW-1:0] w;
    w = XW'(v);
    return w[7:0];
  endfunction

  // Captured request.
  logic [1:0]         act_q;
  logic [7:0]         slot_q;
  logic signed [9:0]  want_q;
  logic               slot_ok_q;
  logic [XW-1:0]      slot_x;
  logic [IW-1:0]      slot_idx;

  // Control registers.
  logic [IW-1:0]          idx_q;
  logic signed [HW-1:0]   top_q, top_d;

  // Restack plan.
  logic signed [HW-1:0]   h_q, dst_q, last_q;
  logic                   dec_q, place_q, top_up_q, top_dn_q;

  // Result registers.
  logic [7:0]         res_slot_q;
  logic               res_ok_q;
  logic [8:0]         res_nh_q;
  logic [8:0]         res_top_q;
  logic               res_redraw_q;

  // Memory ports.
  logic               used_we, used_wdata, used_rd;
  logic [IW-1:0]      used_waddr, used_raddr;
  logic               height_we;
  logic [IW-1:0]      height_waddr;
  logic [HW-1:0]      height_wdata, height_rd;
  logic               order_we;
  logic [IW-1:0]      order_waddr, order_wdata, order_rd;

  // Clamp and plan logic.
  logic signed [HW-1:0] old_h, h_new, src;
  logic signed [CW-1:0] want_c, lim_c, h_c;
  logic signed [HW-1:0] mv_dst, mv_last;
  logic                 mv_dec, mv_place, mv_up, mv_dn, mv_need;
  logic                 act_set, act_free, look_valid;

  assign slot_x   = XW'(slot_q);
  assign slot_idx = slot_x[IW-1:0];
  assign act_set  = (act_q == ACT_SET);
  assign act_free = (act_q == ACT_FREE);

  assign old_h      = height_rd;
  assign look_valid = slot_ok_q && used_rd && (act_set || act_free);

  // Freeing a visible layer restacks it to hidden.
  assign want_c = act_free ? C_NEG : CW'(want_q);
  assign lim_c  = (old_h >= 0) ? CW'(top_q) : CW'(top_q) + C_ONE;
  assign h_c    = (want_c > lim_c) ? lim_c : ((want_c < C_NEG) ? C_NEG : want_c);
  assign h_new  = h_c[HW-1:0];

  always_comb begin
    mv_dst   = old_h;
    mv_last  = old_h;
    mv_dec   = 1'b0;
    mv_place = 1'b0;
    mv_up    = 1'b0;
    mv_dn    = 1'b0;
    mv_need  = 1'b0;
    if (old_h > h_new) begin
      if (h_new >= 0) begin
        // Lowered: layers in between move one place up.
        mv_dec   = 1'b1;
        mv_last  = h_new + H_ONE;
        mv_place = 1'b1;
        mv_need  = 1'b1;
      end else begin
        // Hidden: layers above close the gap.
        mv_last  = top_q - H_ONE;
        mv_dn    = 1'b1;
        mv_need  = (old_h != top_q);
      end
    end else if (old_h < h_new) begin
      if (old_h >= 0) begin
        // Raised: layers in between move one place down.
        mv_last  = h_new - H_ONE;
        mv_place = 1'b1;
        mv_need  = 1'b1;
      end else begin
        // Shown: layers at and above the target open a gap. A layer placed
        // just above the current top moves nothing.
        mv_dec   = 1'b1;
        mv_dst   = top_q + H_ONE;
        mv_last  = h_new + H_ONE;
        mv_place = 1'b1;
        mv_up    = 1'b1;
        mv_need  = (h_new <= top_q);
      end
    end
  end

  assign src = dec_q ? (dst_q - H_ONE) : (dst_q + H_ONE);

  always_comb begin
    top_d = top_q;
    if (top_up_q) begin
      top_d = top_q + H_ONE;
    end else if (top_dn_q) begin
      top_d = top_q - H_ONE;
    end
  end

  // Memory write and read port steering.
  always_comb begin
    used_we      = 1'b0;
    used_waddr   = slot_idx;
    used_wdata   = 1'b0;
    height_we    = 1'b0;
    height_waddr = slot_idx;
    height_wdata = h_new;
    order_we     = 1'b0;
    order_waddr  = dst_q[IW-1:0];
    order_wdata  = order_rd;
    unique case (cmd_i.op)
      DP_CLEAR: begin
        used_we    = 1'b1;
        used_waddr = idx_q;
      end
      DP_SCAN_CHK: begin
        if (!used_rd) begin
          used_we      = 1'b1;
          used_waddr   = idx_q;
          used_wdata   = 1'b1;
          height_we    = 1'b1;
          height_waddr = idx_q;
          height_wdata = H_NEG;
        end
      end
      DP_LOOK_CHK: begin
        height_we = look_valid;
      end
      DP_MOVE_WR: begin
        order_we     = 1'b1;
        height_we    = 1'b1;
        height_waddr = order_rd;
        height_wdata = dst_q;
      end
      DP_FINISH: begin
        order_we    = place_q;
        order_waddr = h_q[IW-1:0];
        order_wdata = slot_idx;
        used_we     = act_free;
      end
      default: begin
      end
    endcase
  end

  assign used_raddr = (cmd_i.op == DP_SCAN_RD) ? idx_q : slot_idx;

  lzot_ram #(.WIDTH(1), .DEPTH(LAYER_COUNT)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .raddr_i (used_raddr),
    .rdata_o (used_rd)
  );

  lzot_ram #(.WIDTH(HW), .DEPTH(LAYER_COUNT)) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (height_we),
    .waddr_i (height_waddr),
    .wdata_i (height_wdata),
    .raddr_i (slot_idx),
    .rdata_o (height_rd)
  );

  lzot_ram #(.WIDTH(IW), .DEPTH(LAYER_COUNT)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (order_we),
    .waddr_i (order_waddr),
    .wdata_i (order_wdata),
    .raddr_i (src[IW-1:0]),
    .rdata_o (order_rd)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      top_q <= H_NEG;
    end else begin
      unique case (cmd_i.op)
        DP_CLEAR: begin
          idx_q <= (idx_q == I_LAST) ? '0 : idx_q + IW'(1);
        end
        DP_CAPTURE: begin
          idx_q <= '0;
        end
        DP_SCAN_CHK: begin
          if (used_rd && (idx_q != I_LAST)) begin
            idx_q <= idx_q + IW'(1);
          end
        end
        DP_FINISH: begin
          top_q <= top_d;
        end
        default: begin
        end
      endcase
    end
  end

  // Request, plan and result registers.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_CAPTURE: begin
        act_q     <= action_i;
        slot_q    <= slot_i;
        want_q    <= wanted_height_i;
        slot_ok_q <= (32'(slot_i) < 32'(LAYER_COUNT));
      end
      DP_SCAN_CHK: begin
        res_slot_q   <= used_rd ? 8'd0 : s8(idx_q);
        res_ok_q     <= !used_rd;
        res_nh_q     <= h9(H_NEG);
        res_top_q    <= h9(top_q);
        res_redraw_q <= 1'b0;
      end
      DP_LOOK_CHK: begin
        h_q          <= h_new;
        dst_q        <= mv_dst;
        last_q       <= mv_last;
        dec_q        <= mv_dec;
        place_q      <= mv_place;
        top_up_q     <= mv_up;
        top_dn_q     <= mv_dn;
        res_slot_q   <= slot_q;
        res_ok_q     <= look_valid;
        res_nh_q     <= (look_valid && act_set) ? h9(h_new) : h9(H_NEG);
        res_top_q    <= h9(top_q);
        res_redraw_q <= look_valid && (act_set ? (h_new != old_h) : (old_h >= 0));
      end
      DP_MOVE_WR: begin
        dst_q <= dec_q ? (dst_q - H_ONE) : (dst_q + H_ONE);
      end
      DP_FINISH: begin
        res_top_q <= h9(top_d);
      end
      default: begin
      end
    endcase
  end

  assign status_o.idx_last   = (idx_q == I_LAST);
  assign status_o.scan_free  = !used_rd;
  assign status_o.look_valid = look_valid;
  assign status_o.need_move  = mv_need;
  assign status_o.move_last  = (dst_q == last_q);

  assign slot_out_o   = res_slot_q;
  assign ok_o         = res_ok_q;
  assign new_height_o = res_nh_q;
  assign top_now_o    = res_top_q;
  assign redraw_o     = res_redraw_q;

  // The stacking top never leaves the pool.
  a_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (top_q >= H_NEG) && (top_q <= H_MAX))
    else $error("stacking top out of range");

  // Every shift step writes an order entry inside the pool.
  a_dst_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_MOVE_WR) |-> ((dst_q >= 0) && (dst_q <= H_MAX)))
    else $error("shift step outside the order list");

  // A layer placed into the order list always lands at a visible height.
  a_place_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_i.op == DP_FINISH) && place_q) |-> (h_q >= 0))
    else $error("layer placed at a hidden height");

endmodule

>>> rtl/layer_z_order_table.sv
// ----------------------------------------------------------------------------
// layer_z_order_table
// Pool of display layers and their stacking order, with allocate, set-height
// and free requests.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; its single result
// appears one cycle with done_o high and must be captured then, since the
// receiver cannot stall it. After reset the block clears every slot of the
// slot-used memory with busy_o high. Every step goes through
// registered-read memories, so each memory access has a read state and a
// use state: an allocate examines slots in turn until it finds a free one
// or reaches the last; a set-height or free looks up the slot, shifts any
// affected layers in the order list with a read and a write state each,
// then finishes, and one that is ignored ends after the lookup.
module layer_z_order_table
  import lzot_pkg::*;
#(
  parameter int LAYER_COUNT = LAYER_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        action_i,
  input  logic [7:0]        slot_i,
  input  logic signed [9:0] wanted_height_i,
  output logic              done_o,
  output logic [7:0]        slot_out_o,
  output logic              ok_o,
  output logic signed [8:0] new_height_o,
  output logic signed [8:0] top_now_o,
  output logic              redraw_o
);

  cmd_t    cmd;
  status_t status;

  lzot_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  lzot_datapath #(.LAYER_COUNT(LAYER_COUNT)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .action_i        (action_i),
    .slot_i          (slot_i),
    .wanted_height_i (wanted_height_i),
    .slot_out_o      (slot_out_o),
    .ok_o            (ok_o),
    .new_height_o    (new_height_o),
    .top_now_o       (top_now_o),
    .redraw_o        (redraw_o)
  );

endmodule
